// File: hdl/segint_pkg.sv
// Shared codes and types for the segment intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none

package segint_pkg;

    localparam logic [1:0] KIND_NONE      = 2'd0;
    localparam logic [1:0] KIND_UNBOUNDED = 2'd1;
    localparam logic [1:0] KIND_BOUNDED   = 2'd2;

    typedef struct packed {
        logic hit;
        logic bounded;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } segint_flags_t;

endpackage

`default_nettype wire

// File: hdl/segint_if.sv
// Request and response channel interfaces of the segment intersection block.
`timescale 1ns / 1ps
`default_nettype none

interface segint_req_if #(parameter int W = 20);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a_start_x;
    logic signed [W-1:0] a_start_y;
    logic signed [W-1:0] a_end_x;
    logic signed [W-1:0] a_end_y;
    logic signed [W-1:0] b_start_x;
    logic signed [W-1:0] b_start_y;
    logic signed [W-1:0] b_end_x;
    logic signed [W-1:0] b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
        output b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
        input  b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

interface segint_rsp_if #(parameter int W = 20);
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic                point_valid;
    logic                saturated;

    modport source (
        output valid, kind, point_x, point_y, point_valid, saturated,
        input  ready
    );
    modport sink (
        input  valid, kind, point_x, point_y, point_valid, saturated,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/segint_front.sv
// Front end: differences, cross products, numerator products, magnitudes.
`timescale 1ns / 1ps
`default_nettype none

module segint_front #(
    parameter int W = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    segint_req_if.sink               req,
    input  logic                     dn_ready,
    output logic                     dn_valid,
    output segint_pkg::segint_flags_t dn_flags,
    output logic [3*W+2:0]           dn_ux,
    output logic [3*W+2:0]           dn_uy,
    output logic [2*W+1:0]           dn_ud,
    output logic signed [W-1:0]      dn_ax0,
    output logic signed [W-1:0]      dn_ay0
);
    import segint_pkg::*;

    localparam int D = W + 1;
    localparam int C = 2 * W + 2;
    localparam int N = 3 * W + 3;

    logic [4:1] en;
    logic [4:1] v_reg;

    // stage 1
    logic signed [D-1:0] dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [D-1:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg;
    logic signed [D-1:0] g0x_reg, g0y_reg, f1x_reg, f1y_reg;
    logic signed [W-1:0] ax1_reg, ay1_reg;
    logic                hit1_reg;
    logic                null_a, null_b;

    // stage 2
    logic signed [C-1:0] r1_reg, r2_reg, r3_reg, r4_reg, den2_reg, num_reg;
    logic signed [D-1:0] dax2_reg, day2_reg;
    logic signed [W-1:0] ax2_reg, ay2_reg;
    logic                hit2_reg;

    // stage 3
    logic signed [N-1:0] nx_reg, ny_reg;
    logic signed [C-1:0] den3_reg;
    logic signed [W-1:0] ax3_reg, ay3_reg;
    logic                hit3_reg, bnd3_reg;

    // stage 4
    logic [N-1:0]        ux_reg, uy_reg;
    logic [C-1:0]        ud_reg;
    logic signed [W-1:0] ax4_reg, ay4_reg;
    segint_flags_t       f4_reg;
    logic [N-1:0]        ux_c, uy_c;
    logic [C-1:0]        ud_c;

    function automatic logic signed [C-1:0] xprod(
        input logic signed [D-1:0] ax,
        input logic signed [D-1:0] ay,
        input logic signed [D-1:0] bx,
        input logic signed [D-1:0] by
    );
        xprod = C'(ax) * C'(by) - C'(ay) * C'(bx);
    endfunction

    function automatic logic same_side(
        input logic signed [C-1:0] p,
        input logic signed [C-1:0] q
    );
        same_side = (p != '0) && (q != '0) && (p[C-1] == q[C-1]);
    endfunction

    assign en[4]     = !v_reg[4] || dn_ready;
    assign en[3]     = !v_reg[3] || en[4];
    assign en[2]     = !v_reg[2] || en[3];
    assign en[1]     = !v_reg[1] || en[2];
    assign req.ready = en[1];

    assign null_a = (req.a_start_x == req.a_end_x) && (req.a_start_y == req.a_end_y);
    assign null_b = (req.b_start_x == req.b_end_x) && (req.b_start_y == req.b_end_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1]) v_reg[1] <= req.valid;
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2];
            if (en[4]) v_reg[4] <= v_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dax_reg  <= D'(req.a_end_x) - D'(req.a_start_x);
            day_reg  <= D'(req.a_end_y) - D'(req.a_start_y);
            dbx_reg  <= D'(req.b_end_x) - D'(req.b_start_x);
            dby_reg  <= D'(req.b_end_y) - D'(req.b_start_y);
            e0x_reg  <= D'(req.b_start_x) - D'(req.a_start_x);
            e0y_reg  <= D'(req.b_start_y) - D'(req.a_start_y);
            e1x_reg  <= D'(req.b_end_x) - D'(req.a_start_x);
            e1y_reg  <= D'(req.b_end_y) - D'(req.a_start_y);
            g0x_reg  <= D'(req.a_start_x) - D'(req.b_start_x);
            g0y_reg  <= D'(req.a_start_y) - D'(req.b_start_y);
            f1x_reg  <= D'(req.a_end_x) - D'(req.b_start_x);
            f1y_reg  <= D'(req.a_end_y) - D'(req.b_start_y);
            ax1_reg  <= req.a_start_x;
            ay1_reg  <= req.a_start_y;
            hit1_reg <= !null_a && !null_b;
        end
        if (en[2])
        begin
            r3_reg   <= xprod(dax_reg, day_reg, e0x_reg, e0y_reg);
            r4_reg   <= xprod(dax_reg, day_reg, e1x_reg, e1y_reg);
            r1_reg   <= xprod(dbx_reg, dby_reg, g0x_reg, g0y_reg);
            r2_reg   <= xprod(dbx_reg, dby_reg, f1x_reg, f1y_reg);
            den2_reg <= xprod(dax_reg, day_reg, dbx_reg, dby_reg);
            num_reg  <= xprod(e0x_reg, e0y_reg, dbx_reg, dby_reg);
            dax2_reg <= dax_reg;
            day2_reg <= day_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            hit2_reg <= hit1_reg;
        end
        if (en[3])
        begin
            nx_reg   <= N'(num_reg) * N'(dax2_reg);
            ny_reg   <= N'(num_reg) * N'(day2_reg);
            den3_reg <= den2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            hit3_reg <= hit2_reg && (den2_reg != '0);
            bnd3_reg <= !same_side(r3_reg, r4_reg) && !same_side(r1_reg, r2_reg);
        end
        if (en[4])
        begin
            ux_reg         <= ux_c;
            uy_reg         <= uy_c;
            ud_reg         <= ud_c;
            ax4_reg        <= ax3_reg;
            ay4_reg        <= ay3_reg;
            f4_reg.hit     <= hit3_reg;
            f4_reg.bounded <= bnd3_reg;
            f4_reg.neg_x   <= nx_reg[N-1] ^ den3_reg[C-1];
            f4_reg.neg_y   <= ny_reg[N-1] ^ den3_reg[C-1];
            f4_reg.ovf_x   <= ux_c >= (N'(ud_c) << (W + 1));
            f4_reg.ovf_y   <= uy_c >= (N'(ud_c) << (W + 1));
        end
    end

    assign ux_c = nx_reg[N-1]   ? N'(-nx_reg)   : N'(nx_reg);
    assign uy_c = ny_reg[N-1]   ? N'(-ny_reg)   : N'(ny_reg);
    assign ud_c = den3_reg[C-1] ? C'(-den3_reg) : C'(den3_reg);

    assign dn_valid = v_reg[4];
    assign dn_flags = f4_reg;
    assign dn_ux    = ux_reg;
    assign dn_uy    = uy_reg;
    assign dn_ud    = ud_reg;
    assign dn_ax0   = ax4_reg;
    assign dn_ay0   = ay4_reg;

endmodule

`default_nettype wire

// File: hdl/segint_div.sv
// Pipelined restoring divider, one quotient bit per stage for both axes.
`timescale 1ns / 1ps
`default_nettype none

module segint_div #(
    parameter int W = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  segint_pkg::segint_flags_t up_flags,
    input  logic [3*W+2:0]            up_ux,
    input  logic [3*W+2:0]            up_uy,
    input  logic [2*W+1:0]            up_ud,
    input  logic signed [W-1:0]       up_ax0,
    input  logic signed [W-1:0]       up_ay0,
    input  logic                      dn_ready,
    output logic                      dn_valid,
    output segint_pkg::segint_flags_t dn_flags,
    output logic [W:0]                dn_qx,
    output logic [W:0]                dn_qy,
    output logic [3*W+2:0]            dn_rx,
    output logic [3*W+2:0]            dn_ry,
    output logic signed [W-1:0]       dn_ax0,
    output logic signed [W-1:0]       dn_ay0
);
    import segint_pkg::*;

    localparam int C = 2 * W + 2;
    localparam int N = 3 * W + 3;

    logic                v_reg  [0:W];
    logic [N-1:0]        rx_reg [0:W];
    logic [N-1:0]        ry_reg [0:W];
    logic [W:0]          qx_reg [0:W];
    logic [W:0]          qy_reg [0:W];
    logic [C-1:0]        ud_reg [0:W];
    logic signed [W-1:0] ax_reg [0:W];
    logic signed [W-1:0] ay_reg [0:W];
    segint_flags_t       f_reg  [0:W];
    logic [W:0]          en;

    for (genvar k = 0; k <= W; k++)
    begin : g_stage
        localparam int SH = W - k;
        logic                v_in;
        logic [N-1:0]        rx_in, ry_in, dsh;
        logic [W:0]          qx_in, qy_in;
        logic [C-1:0]        ud_in;
        logic signed [W-1:0] ax_in, ay_in;
        segint_flags_t       f_in;
        logic [N:0]          tx, ty;

        if (k == 0)
        begin : g_first
            assign v_in  = up_valid;
            assign rx_in = up_ux;
            assign ry_in = up_uy;
            assign qx_in = '0;
            assign qy_in = '0;
            assign ud_in = up_ud;
            assign ax_in = up_ax0;
            assign ay_in = up_ay0;
            assign f_in  = up_flags;
        end
        else
        begin : g_next
            assign v_in  = v_reg[k-1];
            assign rx_in = rx_reg[k-1];
            assign ry_in = ry_reg[k-1];
            assign qx_in = qx_reg[k-1];
            assign qy_in = qy_reg[k-1];
            assign ud_in = ud_reg[k-1];
            assign ax_in = ax_reg[k-1];
            assign ay_in = ay_reg[k-1];
            assign f_in  = f_reg[k-1];
        end

        if (k == W)
        begin : g_last
            assign en[k] = !v_reg[k] || dn_ready;
        end
        else
        begin : g_mid
            assign en[k] = !v_reg[k] || en[k+1];
        end

        assign dsh = N'(ud_in) << SH;
        assign tx  = {1'b0, rx_in} - {1'b0, dsh};
        assign ty  = {1'b0, ry_in} - {1'b0, dsh};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rx_reg[k] <= tx[N] ? rx_in : tx[N-1:0];
                ry_reg[k] <= ty[N] ? ry_in : ty[N-1:0];
                qx_reg[k] <= {qx_in[W-1:0], ~tx[N]};
                qy_reg[k] <= {qy_in[W-1:0], ~ty[N]};
                ud_reg[k] <= ud_in;
                ax_reg[k] <= ax_in;
                ay_reg[k] <= ay_in;
                f_reg[k]  <= f_in;
            end
        end
    end

    assign up_ready = en[0];
    assign dn_valid = v_reg[W];
    assign dn_flags = f_reg[W];
    assign dn_qx    = qx_reg[W];
    assign dn_qy    = qy_reg[W];
    assign dn_rx    = rx_reg[W];
    assign dn_ry    = ry_reg[W];
    assign dn_ax0   = ax_reg[W];
    assign dn_ay0   = ay_reg[W];

endmodule

`default_nettype wire

// File: hdl/segint_out.sv
// Output stage: floor correction, offset by segment A start, clamp, result register.
`timescale 1ns / 1ps
`default_nettype none

module segint_out #(
    parameter int W = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  segint_pkg::segint_flags_t up_flags,
    input  logic [W:0]                up_qx,
    input  logic [W:0]                up_qy,
    input  logic [3*W+2:0]            up_rx,
    input  logic [3*W+2:0]            up_ry,
    input  logic signed [W-1:0]       up_ax0,
    input  logic signed [W-1:0]       up_ay0,
    segint_rsp_if.source              rsp
);
    import segint_pkg::*;

    localparam logic signed [W-1:0] C_MIN = $signed({1'b1, {(W-1){1'b0}}});
    localparam logic signed [W-1:0] C_MAX = $signed({1'b0, {(W-1){1'b1}}});
    localparam logic signed [W+2:0] S_MIN = (W+3)'(C_MIN);
    localparam logic signed [W+2:0] S_MAX = (W+3)'(C_MAX);

    logic                v_reg;
    logic [1:0]          kind_reg;
    logic signed [W-1:0] px_reg, py_reg;
    logic                pv_reg, sat_reg;
    logic                en;
    logic signed [W-1:0] px_c, py_c;
    logic                sx_c, sy_c;

    function automatic logic signed [W-1:0] finish(
        input  logic [W:0]          uq,
        input  logic                rnz,
        input  logic                neg,
        input  logic                ovf,
        input  logic signed [W-1:0] base,
        output logic                sat
    );
        logic [W+2:0]        m;
        logic signed [W+2:0] q;
        logic signed [W+2:0] s;
        m   = {2'b00, uq} + (W+3)'(neg & rnz);
        q   = neg ? -$signed(m) : $signed(m);
        s   = (W+3)'(base) + q;
        sat = 1'b1;
        if (ovf)
            finish = neg ? C_MIN : C_MAX;
        else if (s < S_MIN)
            finish = C_MIN;
        else if (s > S_MAX)
            finish = C_MAX;
        else
        begin
            sat    = 1'b0;
            finish = s[W-1:0];
        end
    endfunction

    always_comb
    begin
        px_c = finish(up_qx, up_rx != '0, up_flags.neg_x, up_flags.ovf_x, up_ax0, sx_c);
        py_c = finish(up_qy, up_ry != '0, up_flags.neg_y, up_flags.ovf_y, up_ay0, sy_c);
    end

    assign en       = !v_reg || rsp.ready;
    assign up_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (up_flags.hit)
            begin
                kind_reg <= up_flags.bounded ? KIND_BOUNDED : KIND_UNBOUNDED;
                px_reg   <= px_c;
                py_reg   <= py_c;
                pv_reg   <= 1'b1;
                sat_reg  <= sx_c || sy_c;
            end
            else
            begin
                kind_reg <= KIND_NONE;
                px_reg   <= '0;
                py_reg   <= '0;
                pv_reg   <= 1'b0;
                sat_reg  <= 1'b0;
            end
        end
    end

    assign rsp.valid       = v_reg;
    assign rsp.kind        = kind_reg;
    assign rsp.point_x     = px_reg;
    assign rsp.point_y     = py_reg;
    assign rsp.point_valid = pv_reg;
    assign rsp.saturated   = sat_reg;

endmodule

`default_nettype wire

// File: hdl/segment_intersection.sv
// Segment intersection top level.
// Usage:
//   req carries one pair of segments per beat (A and B, two endpoints each,
//   signed fixed point of COORD_WIDTH bits); rsp returns one result beat per
//   request beat, in order: kind, crossing point, point_valid, saturated.
//   Both channels are valid/ready; a beat moves when both are high.
// Throughput: one beat per cycle while rsp.ready stays high, with no gaps between items.
// Pipeline: four front stages (differences, cross products, numerator
//   products, magnitudes), one restoring divider stage per quotient bit
//   (COORD_WIDTH + 1), and the output register, between request beat and
//   result beat.
// Every stage holds its own valid bit and advances whenever it is empty or
//   the next stage moves, so bubbles collapse and a stall on rsp fills the
//   pipeline before req.ready falls. Nothing is dropped or repeated.
// Reset: rst_n clears all valid bits; with every stage empty, req.ready is
//   high, so the block takes a request beat as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection #(
    parameter int COORD_WIDTH = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    segint_req_if.sink   req,
    segint_rsp_if.source rsp
);
    import segint_pkg::*;

    localparam int W = COORD_WIDTH;

    logic                fd_valid, fd_ready;
    segint_flags_t       fd_flags;
    logic [3*W+2:0]      fd_ux, fd_uy;
    logic [2*W+1:0]      fd_ud;
    logic signed [W-1:0] fd_ax0, fd_ay0;

    logic                do_valid, do_ready;
    segint_flags_t       do_flags;
    logic [W:0]          do_qx, do_qy;
    logic [3*W+2:0]      do_rx, do_ry;
    logic signed [W-1:0] do_ax0, do_ay0;

    segint_front #(.W(W)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .dn_ready (fd_ready),
        .dn_valid (fd_valid),
        .dn_flags (fd_flags),
        .dn_ux    (fd_ux),
        .dn_uy    (fd_uy),
        .dn_ud    (fd_ud),
        .dn_ax0   (fd_ax0),
        .dn_ay0   (fd_ay0)
    );

    segint_div #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (fd_valid),
        .up_ready (fd_ready),
        .up_flags (fd_flags),
        .up_ux    (fd_ux),
        .up_uy    (fd_uy),
        .up_ud    (fd_ud),
        .up_ax0   (fd_ax0),
        .up_ay0   (fd_ay0),
        .dn_ready (do_ready),
        .dn_valid (do_valid),
        .dn_flags (do_flags),
        .dn_qx    (do_qx),
        .dn_qy    (do_qy),
        .dn_rx    (do_rx),
        .dn_ry    (do_ry),
        .dn_ax0   (do_ax0),
        .dn_ay0   (do_ay0)
    );

    segint_out #(.W(W)) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (do_valid),
        .up_ready (do_ready),
        .up_flags (do_flags),
        .up_qx    (do_qx),
        .up_qy    (do_qy),
        .up_rx    (do_rx),
        .up_ry    (do_ry),
        .up_ax0   (do_ax0),
        .up_ay0   (do_ay0),
        .rsp      (rsp)
    );

    a_pv_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.point_valid == (rsp.kind != KIND_NONE)))
        else $error("point_valid disagrees with kind");

    a_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.point_valid) |->
            (rsp.point_x == '0 && rsp.point_y == '0 && !rsp.saturated))
        else $error("result without a point carries point data");

    a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.saturated) |->
            (rsp.point_x == $signed({1'b1, {(W-1){1'b0}}}) ||
             rsp.point_x == $signed({1'b0, {(W-1){1'b1}}}) ||
             rsp.point_y == $signed({1'b1, {(W-1){1'b0}}}) ||
             rsp.point_y == $signed({1'b0, {(W-1){1'b1}}})))
        else $error("saturated result not at a range limit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (do_valid && !do_ready) |=> (do_valid && $stable(do_qx) && $stable(do_qy)))
        else $error("divider output changed while stalled");

endmodule

`default_nettype wire
